[design/escaped_serial_frame_transmitter_unit_macros.svh]
// ----------------------------------------------------------------------------
// escaped serial frame transmitter - assertion macros
// shared property wrappers, clocked on the rising edge, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ESCAPED_SERIAL_FRAME_TRANSMITTER_UNIT_MACROS_SVH
`define ESCAPED_SERIAL_FRAME_TRANSMITTER_UNIT_MACROS_SVH

// same-cycle implication
`define ESFT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esft assertion failed");

// next-cycle implication
`define ESFT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esft assertion failed");

`endif

[design/esft_pkg.sv]
// ----------------------------------------------------------------------------
// esft_pkg
// types and constants shared by the escaped serial frame transmitter
// ----------------------------------------------------------------------------
package esft_pkg;

   localparam int CODE_W      = 8;
   localparam int LEN_W       = 12;
   localparam int KIND_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;
   localparam int MAX_PACKET_DEFAULT = 2048;

   localparam logic [CODE_W-1:0] ESCAPE_CODE_RST = 8'hDB;
   localparam logic [CODE_W-1:0] END_CODE_RST    = 8'hDE;
   localparam logic [CODE_W-1:0] ACK_CODE_RST    = 8'hDC;
   localparam logic [CODE_W-1:0] REQUEST_CODE_RST = 8'hDD;

   typedef enum logic [KIND_W-1:0] {
      KIND_TX_SLOT   = 3'd0,
      KIND_QUEUE_ACK = 3'd1,
      KIND_QUEUE_REQ = 3'd2,
      KIND_START     = 3'd3,
      KIND_ABORT     = 3'd4
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ESCAPE_CODE  = 2'd0,
      CSR_END_CODE     = 2'd1,
      CSR_ACK_CODE     = 2'd2,
      CSR_REQUEST_CODE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0] escape_code;
      logic [CODE_W-1:0] end_code;
      logic [CODE_W-1:0] ack_code;
      logic [CODE_W-1:0] request_code;
   } cfg_type;

   typedef struct packed {
      logic              tx_valid;
      logic [CODE_W-1:0] tx_byte;
      logic              byte_taken;
      logic              packet_done;
      logic              busy_res;
   } result_type;

endpackage

[design/esft_csr.sv]
// ----------------------------------------------------------------------------
// esft_csr
// code registers written through the plain write port
// ----------------------------------------------------------------------------
module esft_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [esft_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [esft_pkg::CODE_W-1:0]       csr_wdata,
   output esft_pkg::cfg_type                 cfg
);
   import esft_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ESCAPE_CODE:  cfg_in.escape_code  = csr_wdata;
            CSR_END_CODE:     cfg_in.end_code     = csr_wdata;
            CSR_ACK_CODE:     cfg_in.ack_code     = csr_wdata;
            CSR_REQUEST_CODE: cfg_in.request_code = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_code  <= ESCAPE_CODE_RST;
         cfg_ff.end_code     <= END_CODE_RST;
         cfg_ff.ack_code     <= ACK_CODE_RST;
         cfg_ff.request_code <= REQUEST_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/esft_core.sv]
// ----------------------------------------------------------------------------
// esft_core
// framing state, slot priority, escaping; one item per cycle on item_accept
// ----------------------------------------------------------------------------
module esft_core #(
   parameter int MaxPacket = esft_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_accept,
   input  logic [esft_pkg::KIND_W-1:0]       req_type,
   input  logic [esft_pkg::CODE_W-1:0]       data_byte,
   input  logic [esft_pkg::LEN_W-1:0]        packet_length,
   input  esft_pkg::cfg_type                 cfg,
   output esft_pkg::result_type              result
);
   import esft_pkg::*;

   // length cap: parameter limit, then the width of the byte counter
   localparam int LenMax = (1 << LEN_W) - 1;
   localparam int LenCap = (MaxPacket > LenMax) ? LenMax : MaxPacket;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCap);
   localparam logic [16:0]      MAX_PKT = 17'(MaxPacket);

   logic              escape_pending_ff, escape_pending_in;
   logic [CODE_W-1:0] escaped_value_ff,  escaped_value_in;
   logic              ack_pending_ff,    ack_pending_in;
   logic              request_pending_ff, request_pending_in;
   logic              sending_ff,        sending_in;
   logic [LEN_W-1:0]  bytes_left_ff,     bytes_left_in;

   logic              in_range;
   logic [LEN_W-1:0]  start_len;

   assign in_range = (data_byte >= cfg.escape_code) && (data_byte <= cfg.end_code);
   assign start_len = ({5'b0, packet_length} > MAX_PKT) ? LEN_CAP :
                      ((packet_length > LEN_CAP) ? LEN_CAP : packet_length);

   always_comb begin
      escape_pending_in  = escape_pending_ff;
      escaped_value_in   = escaped_value_ff;
      ack_pending_in     = ack_pending_ff;
      request_pending_in = request_pending_ff;
      sending_in         = sending_ff;
      bytes_left_in      = bytes_left_ff;
      result             = '0;

      unique case (req_kind_type'(req_type))
         KIND_TX_SLOT: begin
            if (escape_pending_ff) begin
               result.tx_valid   = 1'b1;
               result.tx_byte    = escaped_value_ff;
               escape_pending_in = 1'b0;
               if (bytes_left_ff != '0) begin
                  bytes_left_in = bytes_left_ff - LEN_W'(1);
               end
            end else if (ack_pending_ff) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = cfg.ack_code;
               ack_pending_in  = 1'b0;
            end else if (request_pending_ff) begin
               result.tx_valid    = 1'b1;
               result.tx_byte     = cfg.request_code;
               request_pending_in = 1'b0;
            end else if (sending_ff) begin
               result.tx_valid = 1'b1;
               if (bytes_left_ff == '0) begin
                  // packet used up: close the frame
                  result.tx_byte     = cfg.end_code;
                  result.packet_done = 1'b1;
                  sending_in         = 1'b0;
               end else if (in_range) begin
                  result.tx_byte    = cfg.escape_code;
                  result.byte_taken = 1'b1;
                  escape_pending_in = 1'b1;
                  escaped_value_in  = data_byte - cfg.escape_code;
               end else begin
                  result.tx_byte    = data_byte;
                  result.byte_taken = 1'b1;
                  bytes_left_in     = bytes_left_ff - LEN_W'(1);
               end
            end
         end
         KIND_QUEUE_ACK: ack_pending_in = 1'b1;
         KIND_QUEUE_REQ: request_pending_in = 1'b1;
         KIND_START: begin
            bytes_left_in = start_len;
            sending_in    = 1'b1;
         end
         KIND_ABORT: begin
            sending_in    = 1'b0;
            bytes_left_in = '0;
         end
         default: ;
      endcase

      result.busy_res = sending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff  <= 1'b0;
         escaped_value_ff   <= '0;
         ack_pending_ff     <= 1'b0;
         request_pending_ff <= 1'b0;
         sending_ff         <= 1'b0;
         bytes_left_ff      <= '0;
      end else if (item_accept) begin
         escape_pending_ff  <= escape_pending_in;
         escaped_value_ff   <= escaped_value_in;
         ack_pending_ff     <= ack_pending_in;
         request_pending_ff <= request_pending_in;
         sending_ff         <= sending_in;
         bytes_left_ff      <= bytes_left_in;
      end
   end

endmodule

[design/escaped_serial_frame_transmitter_unit.sv]
// ----------------------------------------------------------------------------
// escaped_serial_frame_transmitter_unit
// byte-stuffing frame transmitter: one result transaction per request
// ----------------------------------------------------------------------------
//   channel | dir | handshake            | payload
//   req_    | in  | tvalid/tready        | tuser: kind, tdata: byte, length
//   rsp_    | out | tvalid/tready, tlast | tdata: slot result, tlast: done
//   csr_    | in  | we, no wait          | index, wdata (code registers)
//
// one request transaction per cycle while req_tready is high; the result appears in the
// cycle after acceptance, set by the single result register after the slot logic.
// reset (synchronous, active high) clears the framing state, empties the
// result register and loads the default codes.
// a stalled result holds req_tready low only while the result register is
// full and rsp_tready is low; draining and refilling happen in the same cycle.
module escaped_serial_frame_transmitter_unit #(
   parameter int MaxPacket = esft_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [esft_pkg::REQ_DATA_W-1:0]    req_tdata,  // data_byte, packet_length, pad
   input  logic [esft_pkg::KIND_W-1:0]        req_tuser,  // req_type
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [esft_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // tx_valid, tx_byte, byte_taken,
                                                          // busy_res, pad
   output logic                               rsp_tlast,  // packet_done
   // configuration write port
   input  logic                               csr_we,
   input  logic [esft_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [esft_pkg::CODE_W-1:0]        csr_wdata
);
   import esft_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   // take a new request whenever the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   esft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   esft_core #(
      .MaxPacket (MaxPacket)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_accept   (req_accept),
      .req_type      (req_tuser),
      .data_byte     (req_tdata[CODE_W-1:0]),
      .packet_length (req_tdata[CODE_W+LEN_W-1:CODE_W]),
      .cfg           (cfg),
      .result        (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_data_ff.packet_done;
   assign rsp_tdata  = {5'b0,
                        rsp_data_ff.busy_res,
                        rsp_data_ff.byte_taken,
                        rsp_data_ff.tx_byte,
                        rsp_data_ff.tx_valid};

endmodule

[design/esft_checker.sv]
// ----------------------------------------------------------------------------
// esft_checker
// port-level checks on the transmitter, bound to the top level
// ----------------------------------------------------------------------------
`include "escaped_serial_frame_transmitter_unit_macros.svh"

module esft_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [esft_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                               rsp_tlast
);
   import esft_pkg::*;

   // a stalled result keeps its payload
   `ESFT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // every accepted request produces a result next cycle
   `ESFT_ASSERT_NXT(a_req_to_rsp, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // no byte on the line means a zero byte and no read advance
   `ESFT_ASSERT_IMP(a_idle_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[8:1] == 8'd0 && !rsp_tdata[9] && !rsp_tlast)

   // the closing code ends the packet: a byte was sent and the block is no longer busy
   `ESFT_ASSERT_IMP(a_done_idle, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[0] && !rsp_tdata[10] && !rsp_tdata[9])

endmodule

bind escaped_serial_frame_transmitter_unit esft_checker u_esft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - escaped serial frame transmitter testbench
// drives request transactions with random gaps, predicts each slot result
// with a cycle-free software model of the framing logic, and compares every
// result transaction field by field under random back-pressure
// ----------------------------------------------------------------------------
module tb;
   import esft_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int MAX_PACKET   = MAX_PACKET_DEFAULT;
   // start length saturates at the packet limit, then at what the counter holds
   localparam int LEN_CAP      = (MAX_PACKET > (1 << LEN_W) - 1) ? (1 << LEN_W) - 1 : MAX_PACKET;
   // slots spent inside the over-long packet before it is aborted
   localparam int LONG_SLOTS   = 300;
   // request kinds outside the defined set: the block leaves its state alone
   localparam logic [KIND_W-1:0] KIND_RESERVED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RESERVED_HI = 3'd7;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] data;
      logic [LEN_W-1:0]  plen;
   } tx_req_t;

   typedef struct {
      logic              tx_valid;
      logic [CODE_W-1:0] tx_byte;
      logic              byte_taken;
      logic              packet_done;
      logic              busy;
   } slot_result_t;

   // dut signals; the ones driven by the bench are known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // data_byte, packet_length, pad
   logic [KIND_W-1:0]     req_tuser  = '0;  // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // tx_valid, tx_byte, byte_taken, busy_res, pad
   logic                  rsp_tlast;        // packet_done
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CODE_W-1:0]     csr_wdata  = '0;

   // framing model: code registers and state, as left by reset
   logic [CODE_W-1:0] code_escape  = ESCAPE_CODE_RST;
   logic [CODE_W-1:0] code_end     = END_CODE_RST;
   logic [CODE_W-1:0] code_ack     = ACK_CODE_RST;
   logic [CODE_W-1:0] code_request = REQUEST_CODE_RST;
   logic              escape_held  = 1'b0;
   logic [CODE_W-1:0] escape_value = '0;
   logic              ack_queued   = 1'b0;
   logic              req_queued   = 1'b0;
   logic              in_packet    = 1'b0;
   logic [LEN_W-1:0]  bytes_to_go  = '0;

   tx_req_t      pending_reqs[$];   // requests not yet offered to the block
   slot_result_t expected_slots[$]; // predicted results, oldest first

   int  stimulus_count = 0;
   int  mismatches     = 0;
   int  cycle_count    = 0;
   int  idle_pct       = 0;
   int  stall_pct      = 0;
   bit  calm           = 1'b0;      // no gaps and no stalls at the end of the run

   escaped_serial_frame_transmitter_unit #(
      .MaxPacket (MAX_PACKET)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // one request through the framing model; updates state, returns the slot result
   function automatic slot_result_t frame_tx_step(tx_req_t r);
      slot_result_t res;
      res = '{tx_valid: 1'b0, tx_byte: '0, byte_taken: 1'b0, packet_done: 1'b0, busy: 1'b0};
      case (r.kind)
         KIND_TX_SLOT: begin
            // priority: escaped value, ack, request, packet byte or end code
            if (escape_held) begin
               res.tx_valid = 1'b1;
               res.tx_byte  = escape_value;
               escape_held  = 1'b0;
               // read position already moved with the escape byte; count stops at zero
               if (bytes_to_go != 0) bytes_to_go = bytes_to_go - 1'b1;
            end else if (ack_queued) begin
               res.tx_valid = 1'b1;
               res.tx_byte  = code_ack;
               ack_queued   = 1'b0;
            end else if (req_queued) begin
               res.tx_valid = 1'b1;
               res.tx_byte  = code_request;
               req_queued   = 1'b0;
            end else if (in_packet) begin
               res.tx_valid = 1'b1;
               if (bytes_to_go == 0) begin
                  res.tx_byte     = code_end;
                  res.packet_done = 1'b1;
                  in_packet       = 1'b0;
               end else if (r.data >= code_escape && r.data <= code_end) begin
                  // an inverted range never matches, so nothing is escaped
                  res.tx_byte    = code_escape;
                  res.byte_taken = 1'b1;
                  escape_held    = 1'b1;
                  escape_value   = r.data - code_escape;
               end else begin
                  res.tx_byte    = r.data;
                  res.byte_taken = 1'b1;
                  bytes_to_go    = bytes_to_go - 1'b1;
               end
            end
         end
         KIND_QUEUE_ACK: ack_queued = 1'b1;
         KIND_QUEUE_REQ: req_queued = 1'b1;
         KIND_START: begin
            // a held escape and queued codes survive a new start
            bytes_to_go = (r.plen > LEN_CAP) ? LEN_W'(LEN_CAP) : r.plen;
            in_packet   = 1'b1;
         end
         KIND_ABORT: begin
            in_packet   = 1'b0;
            bytes_to_go = '0;
         end
         default: ;
      endcase
      res.busy = in_packet;
      return res;
   endfunction

   task automatic push_req(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] data,
                           logic [LEN_W-1:0] plen);
      pending_reqs.push_back('{kind: kind, data: data, plen: plen});
      stimulus_count++;
   endtask

   // packet byte, leaning toward the escape range and the byte extremes
   function automatic logic [CODE_W-1:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4 && code_escape <= code_end)
         return CODE_W'($urandom_range(code_escape, code_end));
      else if (roll == 4)
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return CODE_W'($urandom_range(0, 255));
   endfunction

   task automatic push_slot();
      push_req(KIND_TX_SLOT, pick_byte(), LEN_W'($urandom));
   endtask

   // mostly whole packets with random content, some code traffic and noise
   task automatic add_traffic(int count);
      int goal, roll, len, slots;
      goal = stimulus_count + count;
      while (stimulus_count < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            push_req(KIND_START, CODE_W'($urandom), LEN_W'(len));
            // worst case every byte escaped, plus the end code
            slots = 2 * len + 1 + $urandom_range(0, 2);
            // some packets are cut short by an abort
            if ($urandom_range(0, 9) == 0) slots = $urandom_range(0, slots);
            for (int i = 0; i < slots; i++) begin
               if ($urandom_range(0, 15) == 0) begin
                  push_req(($urandom_range(0, 1) != 0) ? KIND_QUEUE_ACK : KIND_QUEUE_REQ,
                           CODE_W'($urandom), LEN_W'($urandom));
                  push_slot();
               end
               push_slot();
            end
            if (slots < 2 * len + 1)
               push_req(KIND_ABORT, CODE_W'($urandom), LEN_W'($urandom));
         end else if (roll < 85) begin
            push_req(($urandom_range(0, 1) != 0) ? KIND_QUEUE_ACK : KIND_QUEUE_REQ,
                     CODE_W'($urandom), LEN_W'($urandom));
            repeat ($urandom_range(1, 3)) push_slot();
         end else begin
            // any kind with any field content, reserved kinds included
            push_req(KIND_W'($urandom_range(0, KIND_RESERVED_HI)), CODE_W'($urandom),
                     LEN_W'($urandom));
         end
      end
   endtask

   task automatic write_code(csr_index_type idx, logic [CODE_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ESCAPE_CODE:  code_escape  = value;
         CSR_END_CODE:     code_end     = value;
         CSR_ACK_CODE:     code_ack     = value;
         CSR_REQUEST_CODE: code_request = value;
         default: ;
      endcase
   endtask

   // wait until every request is accepted and every result checked
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_slots.size() != 0);
   endtask

   task automatic run_phase(logic [CODE_W-1:0] esc, logic [CODE_W-1:0] endc,
                            logic [CODE_W-1:0] ack, logic [CODE_W-1:0] reqc,
                            int count, int idle, int stall);
      write_code(CSR_ESCAPE_CODE, esc);
      write_code(CSR_END_CODE, endc);
      write_code(CSR_ACK_CODE, ack);
      write_code(CSR_REQUEST_CODE, reqc);
      idle_pct  = idle;
      stall_pct = stall;
      @(negedge clock);
      add_traffic(count);
      drain();
   endtask

   // request driver: predicts on acceptance, then offers the next queued request
   always @(posedge clock) begin : request_driver
      logic    next_valid;
      tx_req_t offered;
      int      gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_slots.push_back(frame_tx_step(offered));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0) begin
               if (!calm && $urandom_range(0, 99) < idle_pct) begin
                  gap_left = $urandom_range(0, 5);
               end else begin
                  offered    = pending_reqs.pop_front();
                  next_valid = 1'b1;
                  req_tdata  <= {{(REQ_DATA_W - CODE_W - LEN_W){1'b0}}, offered.plen, offered.data};
                  req_tuser  <= offered.kind;
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // result monitor: checks each result transaction, stalls in random bursts
   always @(posedge clock) begin : result_monitor
      slot_result_t exp_slot;
      int           stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_slots.size() == 0) begin
               $display("%0t: result transaction with nothing expected, actual tdata %0h tlast %0b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               exp_slot = expected_slots.pop_front();
               compare_field("tx_valid", 32'(exp_slot.tx_valid), 32'(rsp_tdata[0]));
               compare_field("tx_byte", 32'(exp_slot.tx_byte), 32'(rsp_tdata[8:1]));
               compare_field("byte_taken", 32'(exp_slot.byte_taken), 32'(rsp_tdata[9]));
               compare_field("busy_res", 32'(exp_slot.busy), 32'(rsp_tdata[10]));
               compare_field("packet_done", 32'(exp_slot.packet_done), 32'(rsp_tlast));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[escaped_serial_frame_transmitter_unit] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_pct  = 30;
      stall_pct = 30;

      // directed part with reset codes: escape DB..DE, ack DC, request DD, end DE
      push_req(KIND_TX_SLOT, 8'hFF, 12'hFFF);     // idle slot, nothing to send
      push_req(KIND_RESERVED_LO, 8'hFF, 12'hFFF); // reserved kinds change nothing
      push_req(3'd6, 8'h00, 12'h000);
      push_req(KIND_RESERVED_HI, 8'hA5, 12'h5A5);
      push_req(KIND_QUEUE_ACK, 8'h00, 12'h000);
      push_req(KIND_QUEUE_REQ, 8'h00, 12'h000);
      push_req(KIND_START, 8'h00, 12'd3);
      push_req(KIND_TX_SLOT, 8'h11, 12'h000);     // ack before packet bytes
      push_req(KIND_TX_SLOT, 8'h22, 12'h000);     // then request
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);
      push_req(KIND_TX_SLOT, 8'hFF, 12'h000);
      push_req(KIND_TX_SLOT, 8'hDE, 12'h000);     // top of escape range
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);     // escaped value goes out
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);     // end code closes the packet
      // escape held across an abort, count already at zero
      push_req(KIND_START, 8'h00, 12'd1);
      push_req(KIND_TX_SLOT, 8'hDB, 12'h000);
      push_req(KIND_ABORT, 8'h00, 12'h000);
      push_req(KIND_QUEUE_ACK, 8'h00, 12'h000);
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);     // escaped value wins over the ack
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);
      // a new start keeps a held escape
      push_req(KIND_START, 8'h00, 12'd2);
      push_req(KIND_TX_SLOT, 8'hDC, 12'h000);
      push_req(KIND_START, 8'h00, 12'd0);
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);
      push_req(KIND_TX_SLOT, 8'h00, 12'h000);

      // one over-long packet, saturated to the packet limit, then aborted
      push_req(KIND_START, 8'h00, LEN_W'($urandom_range(MAX_PACKET + 1, (1 << LEN_W) - 1)));
      repeat (LONG_SLOTS)
         push_req(KIND_TX_SLOT, CODE_W'($urandom), LEN_W'($urandom));
      push_req(KIND_ABORT, 8'h00, 12'h000);
      add_traffic(200);
      drain();

      // every byte escaped
      run_phase(8'h00, 8'hFF, 8'h00, 8'hFF, 200, 10, 40);
      // inverted range, nothing escaped
      run_phase(8'hF0, 8'h10, 8'hFF, 8'h00, 200, 40, 10);
      // single-value ranges at both ends, a stretch with no gaps
      run_phase(8'hFF, 8'hFF, CODE_W'($urandom), CODE_W'($urandom), 150, 0, 0);
      run_phase(8'h00, 8'h00, CODE_W'($urandom), CODE_W'($urandom), 150, 20, 20);
      run_phase(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                CODE_W'($urandom), 200, 15, 15);
      calm = 1'b1;
      run_phase(8'h40, 8'h7F, 8'h55, 8'hAA, 150, 0, 0);

      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("[escaped_serial_frame_transmitter_unit] OK");
      else
         $display("[escaped_serial_frame_transmitter_unit] ERROR");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/esft_pkg.sv
design/esft_csr.sv
design/esft_core.sv
design/escaped_serial_frame_transmitter_unit.sv
design/esft_checker.sv
tb/sv/tb.sv
